FILE: hw/rtl/sdram_bank_command_model_core_defines.svh
// Assertion macros for the SDRAM bank command model.
// Included by modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef SDRAM_BANK_COMMAND_MODEL_CORE_DEFINES_SVH
`define SDRAM_BANK_COMMAND_MODEL_CORE_DEFINES_SVH

// same-cycle implication
`define SBCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sbcm_pkg.sv
// Shared types, constants and helpers for the SDRAM bank command model.
// No dependencies; imported by sbcm_word_store and the top level.
package sbcm_pkg;

    localparam int BANK_BITS   = 1;
    localparam int ROW_BITS    = 11;
    localparam int COL_BITS    = 8;
    localparam int NBANKS      = 1 << BANK_BITS;
    localparam int STORE_W     = BANK_BITS + ROW_BITS + COL_BITS;
    localparam int STORE_DEPTH = 1 << STORE_W;

    localparam int ADDR_W = 12;
    localparam int DATA_W = 16;
    localparam int CFG_W  = 9;
    localparam int LEN_W  = 9;
    localparam int CNT_W  = 4;
    localparam int A10    = 10;

    localparam logic [DATA_W-1:0] FILL_WORD = 16'hFEFE;
    localparam logic [DATA_W-1:0] IDLE_WORD = 16'hE7E7;

    typedef enum logic [2:0] {
        OP_MODE       = 3'd0,
        OP_REFRESH    = 3'd1,
        OP_PRECHARGE  = 3'd2,
        OP_ACTIVATE   = 3'd3,
        OP_WRITE      = 3'd4,
        OP_READ       = 3'd5,
        OP_BURST_STOP = 3'd6,
        OP_NOP        = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        BS_UNKNOWN     = 3'd0,
        BS_IDLE        = 3'd1,
        BS_ACTIVE      = 3'd2,
        BS_READING     = 3'd3,
        BS_WRITING     = 3'd4,
        BS_PRECHARGING = 3'd5,
        BS_OPENING     = 3'd7
    } bank_state_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_READ  = 2'd1,
        BK_WRITE = 2'd2
    } burst_kind_t;

    typedef enum logic [1:0] {
        CFG_READ_LEN  = 2'd0,
        CFG_WRITE_LEN = 2'd1,
        CFG_PRE_DELAY = 2'd2,
        CFG_ACT_DELAY = 2'd3
    } cfg_index_t;

    typedef struct packed {
        bank_state_t        state;
        logic [CNT_W-1:0]   count;
    } bank_t;

    typedef struct packed {
        logic               en;
        logic               we;
        logic [STORE_W-1:0] addr;
        logic [DATA_W-1:0]  wdata;
    } store_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               read_valid;
        logic               protocol_error;
    } result_t;

    function automatic bank_t start_timed(bank_state_t waiting, bank_state_t target,
                                          logic [CNT_W-1:0] delay);
        bank_t b;
        if (delay <= CNT_W'(1)) begin
            b.state = target;
            b.count = '0;
        end else begin
            b.state = waiting;
            b.count = delay - 1'b1;
        end
        return b;
    endfunction

    function automatic bank_t finish_bank(bank_t cur, logic ap, logic [CNT_W-1:0] pre_delay);
        bank_t b;
        if (ap) begin
            b = start_timed(BS_PRECHARGING, BS_IDLE, pre_delay);
        end else begin
            b.state = BS_ACTIVE;
            b.count = cur.count;
        end
        return b;
    endfunction

endpackage

FILE: hw/rtl/sbcm_word_store.sv
// Word store of the SDRAM model: single-port synchronous RAM, registered read.
// Sweeps every word to the fill pattern after reset. Uses sbcm_pkg.
module sbcm_word_store
    import sbcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  store_req_t        req,
    output logic [DATA_W-1:0] rdata,
    output logic              clearing
);

    logic [DATA_W-1:0]  mem [STORE_DEPTH];
    logic [DATA_W-1:0]  rdata_reg;
    logic [STORE_W-1:0] clear_addr_reg;
    logic               clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            clearing_reg   <= 1'b1;
        end
        else if (clearing_reg)
        begin
            if (clear_addr_reg == '1)
            begin
                clearing_reg <= 1'b0;
            end
            clear_addr_reg <= clear_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clear_addr_reg] <= FILL_WORD;
        end
        else if (req.en && req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.en && !req.we)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clearing_reg;

endmodule

FILE: hw/rtl/sdram_bank_command_model_core.sv
// Top level of the SDRAM bank command model: bank timers, burst engine, output buffer.
// Uses sbcm_pkg, sbcm_word_store and sdram_bank_command_model_core_defines.svh.
//
//  channel | signals                                          | role
//  --------+--------------------------------------------------+-----------------
//  in      | in_valid in_stall command address write_data     | one command/clock unless in_stall
//  out     | out_valid out_stall read_data read_valid         | one result per
//          | protocol_error                                   | command
//  cfg     | cfg_write_enable cfg_index cfg_data              | register write
//
// One command per cycle while in_stall is low; its result is registered into the output buffer.
// The word store's single port makes one burst access per command.
// After reset the store is swept to the fill word, with in_stall high throughout the sweep.
// A two-entry output buffer absorbs out_stall; in_stall rises once both are full.
`include "sdram_bank_command_model_core_defines.svh"

module sdram_bank_command_model_core
    import sbcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        command,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] read_data,
    output logic              read_valid,
    output logic              protocol_error,
    input  logic              cfg_write_enable,
    input  logic [1:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    logic [LEN_W-1:0]    rd_len_reg;
    logic [LEN_W-1:0]    wr_len_reg;
    logic [CNT_W-1:0]    pre_delay_reg;
    logic [CNT_W-1:0]    act_delay_reg;

    bank_t               bank_reg      [NBANKS];
    bank_t               bank_next     [NBANKS];
    logic [ROW_BITS-1:0] open_row_reg  [NBANKS];
    logic [ROW_BITS-1:0] open_row_next [NBANKS];
    burst_kind_t         burst_kind_reg, burst_kind_next;
    logic [BANK_BITS-1:0] burst_bank_reg, burst_bank_next;
    logic [LEN_W-1:0]    burst_rem_reg, burst_rem_next;
    logic [STORE_W-1:0]  burst_addr_reg, burst_addr_next;
    logic                burst_ap_reg, burst_ap_next;
    logic                pend_valid_reg, pend_valid_next;

    result_t             main_reg, skid_reg, result;
    logic                main_valid_reg, skid_valid_reg;

    store_req_t          store_req;
    logic [DATA_W-1:0]   store_rdata;
    logic                store_clearing;
    logic                in_accept, out_accept;
    bank_state_t         burst_bank_state;

    sbcm_word_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (store_req),
        .rdata    (store_rdata),
        .clearing (store_clearing)
    );

    assign in_stall   = skid_valid_reg || store_clearing;
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = main_valid_reg;
    assign out_accept = main_valid_reg && !out_stall;

    assign read_data      = main_reg.read_data;
    assign read_valid     = main_reg.read_valid;
    assign protocol_error = main_reg.protocol_error;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_len_reg    <= LEN_W'(1);
            wr_len_reg    <= LEN_W'(1);
            pre_delay_reg <= CNT_W'(3);
            act_delay_reg <= CNT_W'(3);
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_READ_LEN:  rd_len_reg    <= cfg_data[LEN_W-1:0];
                CFG_WRITE_LEN: wr_len_reg    <= cfg_data[LEN_W-1:0];
                CFG_PRE_DELAY: pre_delay_reg <= cfg_data[CNT_W-1:0];
                CFG_ACT_DELAY: act_delay_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin : step_logic
        logic [ADDR_W+BANK_BITS-1:0] addr_ext;
        logic [BANK_BITS-1:0]        a_bank;
        logic [ROW_BITS-1:0]         a_row;
        logic [COL_BITS-1:0]         a_col;
        logic                        a10;
        bank_state_t                 sel_state;
        logic [ROW_BITS-1:0]         sel_row;
        logic [LEN_W-1:0]            len;
        logic                        err;
        logic                        legal;

        addr_ext = {{BANK_BITS{1'b0}}, address};
        a_bank   = BANK_BITS'(addr_ext >> ROW_BITS);
        a_row    = ROW_BITS'(address);
        a_col    = address[COL_BITS-1:0];
        a10      = address[A10];
        err      = 1'b0;
        legal    = 1'b0;
        len      = '0;

        bank_next       = bank_reg;
        open_row_next   = open_row_reg;
        burst_kind_next = burst_kind_reg;
        burst_bank_next = burst_bank_reg;
        burst_rem_next  = burst_rem_reg;
        burst_addr_next = burst_addr_reg;
        burst_ap_next   = burst_ap_reg;
        pend_valid_next = 1'b0;
        store_req       = '0;

        for (int n = 0; n < NBANKS; n++)
        begin
            if (bank_next[n].count != '0)
            begin
                bank_next[n].count = bank_next[n].count - 1'b1;
                if (bank_next[n].count == '0)
                begin
                    if (bank_next[n].state == BS_PRECHARGING)
                    begin
                        bank_next[n].state = BS_IDLE;
                    end
                    else if (bank_next[n].state == BS_OPENING)
                    begin
                        bank_next[n].state = BS_ACTIVE;
                    end
                end
            end
        end

        sel_state = BS_UNKNOWN;
        sel_row   = '0;
        for (int n = 0; n < NBANKS; n++)
        begin
            if (BANK_BITS'(n) == a_bank)
            begin
                sel_state = bank_next[n].state;
                sel_row   = open_row_reg[n];
            end
        end

        case (cmd_t'(command))
            OP_MODE, OP_REFRESH:
            begin
                for (int n = 0; n < NBANKS; n++)
                begin
                    if (bank_next[n].state != BS_IDLE)
                    begin
                        err = 1'b1;
                    end
                end
            end
            OP_PRECHARGE:
            begin
                for (int n = 0; n < NBANKS; n++)
                begin
                    if ((a10 || BANK_BITS'(n) == a_bank) &&
                        (bank_next[n].state == BS_PRECHARGING ||
                         bank_next[n].state == BS_OPENING))
                    begin
                        err = 1'b1;
                    end
                end
                if (!err)
                begin
                    for (int n = 0; n < NBANKS; n++)
                    begin
                        if (a10 || BANK_BITS'(n) == a_bank)
                        begin
                            if (bank_next[n].state == BS_READING ||
                                bank_next[n].state == BS_WRITING)
                            begin
                                bank_next[n].state = BS_ACTIVE;
                                burst_kind_next    = BK_IDLE;
                            end
                            else if (bank_next[n].state == BS_ACTIVE ||
                                     bank_next[n].state == BS_UNKNOWN)
                            begin
                                bank_next[n] = start_timed(BS_PRECHARGING, BS_IDLE,
                                                           pre_delay_reg);
                            end
                        end
                    end
                end
            end
            OP_ACTIVATE:
            begin
                if (sel_state != BS_IDLE)
                begin
                    err = 1'b1;
                end
                else
                begin
                    for (int n = 0; n < NBANKS; n++)
                    begin
                        if (BANK_BITS'(n) == a_bank)
                        begin
                            open_row_next[n] = a_row;
                            bank_next[n] = start_timed(BS_OPENING, BS_ACTIVE, act_delay_reg);
                        end
                    end
                end
            end
            OP_WRITE, OP_READ:
            begin
                legal = sel_state == BS_ACTIVE || sel_state == BS_READING ||
                        sel_state == BS_WRITING;
                if (sel_state == BS_ACTIVE && burst_kind_next != BK_IDLE)
                begin
                    // other bank's burst ends before this one starts
                    burst_kind_next = BK_IDLE;
                    for (int n = 0; n < NBANKS; n++)
                    begin
                        if (BANK_BITS'(n) == burst_bank_next)
                        begin
                            bank_next[n] = finish_bank(bank_next[n], burst_ap_next,
                                                       pre_delay_reg);
                        end
                    end
                end
                if (!legal)
                begin
                    err = 1'b1;
                end
                else
                begin
                    for (int n = 0; n < NBANKS; n++)
                    begin
                        if (BANK_BITS'(n) == a_bank)
                        begin
                            bank_next[n].state = (cmd_t'(command) == OP_WRITE) ?
                                                 BS_WRITING : BS_READING;
                        end
                    end
                    if (cmd_t'(command) == OP_WRITE)
                    begin
                        burst_kind_next = BK_WRITE;
                        len = wr_len_reg;
                    end
                    else
                    begin
                        burst_kind_next = BK_READ;
                        len = rd_len_reg;
                    end
                    burst_rem_next  = (len == '0) ? LEN_W'(1) : len;
                    burst_bank_next = a_bank;
                    burst_addr_next = {a_bank, sel_row, a_col};
                    burst_ap_next   = a10;
                end
            end
            OP_BURST_STOP:
            begin
                if (burst_kind_next != BK_IDLE)
                begin
                    burst_kind_next = BK_IDLE;
                    for (int n = 0; n < NBANKS; n++)
                    begin
                        if (BANK_BITS'(n) == burst_bank_next)
                        begin
                            bank_next[n] = finish_bank(bank_next[n], burst_ap_next,
                                                       pre_delay_reg);
                        end
                    end
                end
            end
            default: ;
        endcase

        if (burst_kind_next != BK_IDLE)
        begin
            store_req.en    = in_accept;
            store_req.addr  = burst_addr_next;
            store_req.wdata = write_data;
            if (burst_kind_next == BK_WRITE)
            begin
                store_req.we = 1'b1;
            end
            else
            begin
                pend_valid_next = 1'b1;
            end
            burst_rem_next = burst_rem_next - 1'b1;
            if (burst_rem_next == '0)
            begin
                burst_kind_next = BK_IDLE;
                for (int n = 0; n < NBANKS; n++)
                begin
                    if (BANK_BITS'(n) == burst_bank_next)
                    begin
                        bank_next[n] = finish_bank(bank_next[n], burst_ap_next,
                                                   pre_delay_reg);
                    end
                end
            end
            else
            begin
                burst_addr_next = {burst_addr_next[STORE_W-1:COL_BITS],
                                   COL_BITS'(burst_addr_next[COL_BITS-1:0] + 1'b1)};
            end
        end

        result.read_data      = pend_valid_reg ? store_rdata : IDLE_WORD;
        result.read_valid     = pend_valid_reg;
        result.protocol_error = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NBANKS; n++)
            begin
                bank_reg[n]     <= '{state: BS_UNKNOWN, count: '0};
                open_row_reg[n] <= '0;
            end
            burst_kind_reg <= BK_IDLE;
            burst_bank_reg <= '0;
            burst_rem_reg  <= '0;
            burst_addr_reg <= '0;
            burst_ap_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            bank_reg       <= bank_next;
            open_row_reg   <= open_row_next;
            burst_kind_reg <= burst_kind_next;
            burst_bank_reg <= burst_bank_next;
            burst_rem_reg  <= burst_rem_next;
            burst_addr_reg <= burst_addr_next;
            burst_ap_reg   <= burst_ap_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // two-entry output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_accept)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (main_valid_reg && !out_accept)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_accept)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (in_accept)
        begin
            if (main_valid_reg && !out_accept)
            begin
                skid_reg <= result;
            end
            else
            begin
                main_reg <= result;
            end
        end
    end

    always_comb
    begin
        burst_bank_state = BS_UNKNOWN;
        for (int n = 0; n < NBANKS; n++)
        begin
            if (BANK_BITS'(n) == burst_bank_reg)
            begin
                burst_bank_state = bank_reg[n].state;
            end
        end
    end

    `SBCM_ASSERT_NOW(a_burst_bank_busy, burst_kind_reg != BK_IDLE,
        burst_bank_state == BS_READING || burst_bank_state == BS_WRITING,
        "burst running on a bank that is not reading or writing")
    `SBCM_ASSERT_NEXT(a_read_pending, in_accept && burst_kind_next == BK_READ,
        pend_valid_reg, "read transfer did not leave a pending word")
    `SBCM_ASSERT_NOW(a_skid_behind_main, skid_valid_reg, main_valid_reg,
        "skid entry held with empty main entry")
    `SBCM_ASSERT_NOW(a_timer_state, bank_reg[0].count != '0,
        bank_reg[0].state == BS_PRECHARGING || bank_reg[0].state == BS_OPENING,
        "bank timer running outside a timed state")

endmodule
